### hw/rtl/sactl_pkg.sv
// Shared types, codes and the byte-enable decoder of the cache tag controller.
package sactl_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 80;

  localparam logic [1:0] StatusErr  = 2'd0;
  localparam logic [1:0] StatusMiss = 2'd1;
  localparam logic [1:0] StatusHit  = 2'd2;

  localparam logic [1:0] WidthByte   = 2'd0;
  localparam logic [1:0] WidthHalf   = 2'd1;
  localparam logic [1:0] WidthWord   = 2'd2;
  localparam logic [1:0] WidthDouble = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [2:0] lane;
    logic [1:0] wcode;
  } be_dec_t;

  typedef struct packed {
    logic hit;
    logic fill;
    logic touch;
  } lookup_t;

  function automatic be_dec_t decode_be(input logic [7:0] be);
    be_dec_t d;
    d = '{ok: 1'b1, lane: 3'd0, wcode: WidthDouble};
    unique case (be)
      8'h01: begin d.lane = 3'd0; d.wcode = WidthByte; end
      8'h02: begin d.lane = 3'd1; d.wcode = WidthByte; end
      8'h04: begin d.lane = 3'd2; d.wcode = WidthByte; end
      8'h08: begin d.lane = 3'd3; d.wcode = WidthByte; end
      8'h10: begin d.lane = 3'd4; d.wcode = WidthByte; end
      8'h20: begin d.lane = 3'd5; d.wcode = WidthByte; end
      8'h40: begin d.lane = 3'd6; d.wcode = WidthByte; end
      8'h80: begin d.lane = 3'd7; d.wcode = WidthByte; end
      8'h03: begin d.lane = 3'd0; d.wcode = WidthHalf; end
      8'h0C: begin d.lane = 3'd1; d.wcode = WidthHalf; end
      8'h30: begin d.lane = 3'd2; d.wcode = WidthHalf; end
      8'hC0: begin d.lane = 3'd3; d.wcode = WidthHalf; end
      8'h0F: begin d.lane = 3'd0; d.wcode = WidthWord; end
      8'hF0: begin d.lane = 3'd1; d.wcode = WidthWord; end
      8'hFF: begin d.lane = 3'd0; d.wcode = WidthDouble; end
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### hw/rtl/set_assoc_cache_tag_lru_top.sv
// Top level of the set-associative write-through cache tag and LRU controller.
// One bus access is taken per cycle while the output is not held back and no
// clearing pass runs. The set row (valid bits, tags and ages of all ways) is
// read from a single synchronous memory in the accept cycle, compared and
// updated in the next cycle and written back; a row written back while the
// next access reads the same set is forwarded. A result is held in stage 1
// and then in an output register. After reset a clearing pass writes every
// set row, one per cycle, before the first access is accepted.
module set_assoc_cache_tag_lru_top import sactl_pkg::*; #(
  parameter int LINE_OFFSET_BITS = 5,
  parameter int CACHE_SIZE_BITS  = 18,
  parameter int WAY_BITS         = 2,
  parameter int ADDRESS_BITS     = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // address[31:0], byte_enable[39:32], burst[40], zero[47:41]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // action (0 read, 1 write)
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // status[1:0], hit_flag[2], chosen_way[4:3], access_address[36:5],
  // width_code[38:37], fill_request[39], fill_line_address[71:40],
  // write_through[72], zero[79:73]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int SetBitsRaw = CACHE_SIZE_BITS - LINE_OFFSET_BITS - WAY_BITS;
  localparam int SetBits    = (SetBitsRaw > 0) ? SetBitsRaw : 0;
  localparam int SetW       = (SetBits > 0) ? SetBits : 1;
  localparam int NumSets    = 1 << SetBits;
  localparam int NumWays    = 1 << WAY_BITS;
  localparam int WayW       = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int TagShift   = SetBits + LINE_OFFSET_BITS;
  localparam int TagBits    = (ADDRESS_BITS > TagShift) ? ADDRESS_BITS - TagShift : 0;
  localparam int TagW       = (TagBits > 0) ? TagBits : 1;
  localparam int RowW       = NumWays * (1 + TagW + WayW);
  localparam logic [31:0] AddrMask = 32'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [31:0] LineMask = 32'((64'd1 << LINE_OFFSET_BITS) - 64'd1);
  localparam logic [SetW-1:0] LastSet = SetW'(NumSets - 1);

  // input side
  logic            s_accept;
  be_dec_t         dec;
  logic [5:0]      lane_off;
  logic [31:0]     in_addr;
  logic [SetW-1:0] in_set;

  // stage 1
  logic            s1_valid_q;
  logic            s1_err_q;
  logic            s1_write_q;
  logic [31:0]     s1_addr_q;
  logic [1:0]      s1_wcode_q;
  logic [SetW-1:0] s1_set_q;
  logic [TagW-1:0] s1_tag_q;
  logic            advance;
  logic            s1_wr_en;

  // memory and forwarding
  logic [RowW-1:0] mem [NumSets];
  logic [RowW-1:0] rd_row_q;
  logic [RowW-1:0] fwd_row_q;
  logic            fwd_hit_q;
  logic [RowW-1:0] cur_row;
  logic [RowW-1:0] new_row;
  logic [RowW-1:0] clr_row;
  logic            mem_we;
  logic [SetW-1:0] mem_wa;
  logic [RowW-1:0] mem_wd;

  logic [NumWays-1:0]                 cur_valid, new_valid, clr_valid;
  logic [NumWays-1:0][TagW-1:0]       cur_tag, new_tag, clr_tag;
  logic [NumWays-1:0][WayW-1:0]       cur_age, new_age, clr_age;
  logic [WayW-1:0]                    sel_way;
  lookup_t                            lookup;

  // clearing pass
  logic            clr_active_q;
  logic [SetW-1:0] clr_idx_q;

  // output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] out_data_d;

  // ---------------- accept and address decode ----------------
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !clr_active_q && (!s1_valid_q || advance);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (s_axis_tdata_i[40]) begin
      dec = '{ok: 1'b1, lane: 3'd0, wcode: WidthDouble};
    end else begin
      dec = decode_be(s_axis_tdata_i[39:32]);
    end
  end

  assign lane_off = 6'(dec.lane) << dec.wcode;
  assign in_addr  = (s_axis_tdata_i[31:0] + 32'(lane_off)) & AddrMask;
  assign in_set   = (SetBits == 0) ? '0 : SetW'(in_addr >> LINE_OFFSET_BITS);

  // ---------------- set row memory ----------------
  assign s1_wr_en = s1_valid_q && !s1_err_q && advance;
  assign mem_we   = clr_active_q || s1_wr_en;
  assign mem_wa   = clr_active_q ? clr_idx_q : s1_set_q;
  assign mem_wd   = clr_active_q ? clr_row : new_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (s_accept) rd_row_q <= mem[in_set];
  end

  always_comb begin
    for (int w = 0; w < NumWays; w++) begin
      clr_valid[w] = 1'b0;
      clr_tag[w]   = '0;
      clr_age[w]   = WayW'(w);
    end
  end
  assign clr_row = {clr_age, clr_tag, clr_valid};

  // Take the row being written back when it belongs to the same set.
  assign cur_row = fwd_hit_q ? fwd_row_q : rd_row_q;
  assign {cur_age, cur_tag, cur_valid} = cur_row;
  assign new_row = {new_age, new_tag, new_valid};

  sactl_way_ctrl #(
    .WAY_BITS (WAY_BITS),
    .TAG_W    (TagW)
  ) u_way_ctrl (
    .valid_i      (cur_valid),
    .tag_i        (cur_tag),
    .age_i        (cur_age),
    .lookup_tag_i (s1_tag_q),
    .is_write_i   (s1_write_q),
    .way_o        (sel_way),
    .res_o        (lookup),
    .valid_o      (new_valid),
    .tag_o        (new_tag),
    .age_o        (new_age)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      fwd_hit_q    <= 1'b0;
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
    end else begin
      if (clr_active_q) begin
        clr_idx_q <= clr_idx_q + SetW'(1);
        if (clr_idx_q == LastSet) clr_active_q <= 1'b0;
      end
      if (s_accept) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= s1_wr_en && (s1_set_q == in_set);
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) out_valid_q <= s1_valid_q;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_err_q   <= !dec.ok;
      s1_write_q <= s_axis_tuser_i;
      s1_addr_q  <= in_addr;
      s1_wcode_q <= dec.wcode;
      s1_set_q   <= in_set;
      s1_tag_q   <= TagW'(in_addr >> TagShift);
      fwd_row_q  <= new_row;
    end
    if (advance && s1_valid_q) out_data_q <= out_data_d;
  end

  always_comb begin
    out_data_d = '0;
    if (!s1_err_q) begin
      out_data_d[1:0]   = (!s1_write_q && lookup.hit) ? StatusHit : StatusMiss;
      out_data_d[2]     = lookup.hit;
      out_data_d[4:3]   = 2'(sel_way);
      out_data_d[36:5]  = s1_addr_q;
      out_data_d[38:37] = s1_wcode_q;
      out_data_d[39]    = lookup.fill;
      out_data_d[71:40] = lookup.fill ? (s1_addr_q & ~LineMask) : 32'd0;
      out_data_d[72]    = s1_write_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // ---------------- assertions ----------------
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s_axis_tready_o && !s1_valid_q)
    else $error("access taken during clearing pass");

  a_fill_on_read_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[39]) |->
      (out_data_q[1:0] == StatusMiss) && !out_data_q[72] && !out_data_q[2])
    else $error("fill request on a hit or a write");

  a_fwd_same_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && s1_wr_en && (s1_set_q == in_set) |=> fwd_hit_q)
    else $error("back-to-back same-set access not forwarded");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_active_q) |-> $past(clr_idx_q) == LastSet)
    else $error("clearing pass ended early");

endmodule

### hw/rtl/sactl_way_ctrl.sv
// Tag compare, oldest-way search and age update for one set row.
module sactl_way_ctrl import sactl_pkg::*; #(
  parameter int WAY_BITS = 2,
  parameter int TAG_W    = 16
) (
  input  logic [(1<<WAY_BITS)-1:0]                                    valid_i,
  input  logic [(1<<WAY_BITS)-1:0][TAG_W-1:0]                         tag_i,
  input  logic [(1<<WAY_BITS)-1:0][((WAY_BITS > 0) ? WAY_BITS : 1)-1:0] age_i,
  input  logic [TAG_W-1:0]                                            lookup_tag_i,
  input  logic                                                        is_write_i,
  output logic [((WAY_BITS > 0) ? WAY_BITS : 1)-1:0]                  way_o,
  output lookup_t                                                     res_o,
  output logic [(1<<WAY_BITS)-1:0]                                    valid_o,
  output logic [(1<<WAY_BITS)-1:0][TAG_W-1:0]                         tag_o,
  output logic [(1<<WAY_BITS)-1:0][((WAY_BITS > 0) ? WAY_BITS : 1)-1:0] age_o
);

  localparam int NumWays = 1 << WAY_BITS;
  localparam int WayW    = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam logic [WayW-1:0] AgeMask = WayW'(NumWays - 1);

  logic [NumWays-1:0] match;
  logic [WayW-1:0]    lru;
  logic [WayW-1:0]    hit_way;
  logic [WayW-1:0]    cur_age;
  logic               found;

  always_comb begin
    for (int w = 0; w < NumWays; w++) begin
      match[w] = valid_i[w] && (tag_i[w] == lookup_tag_i);
    end
  end

  // Oldest way, lowest index wins ties; first matching way on a hit.
  always_comb begin
    lru     = '0;
    hit_way = '0;
    found   = 1'b0;
    for (int w = 0; w < NumWays; w++) begin
      if (age_i[w] > age_i[lru]) lru = WayW'(w);
      if (!found && match[w]) begin
        found   = 1'b1;
        hit_way = WayW'(w);
      end
    end
  end

  assign way_o       = found ? hit_way : lru;
  assign res_o.hit   = found;
  assign res_o.fill  = !is_write_i && !found;
  assign res_o.touch = found || !is_write_i;
  assign cur_age     = age_i[way_o];

  always_comb begin
    valid_o = valid_i;
    tag_o   = tag_i;
    age_o   = age_i;
    if (res_o.touch) begin
      for (int w = 0; w < NumWays; w++) begin
        if (age_i[w] < cur_age) age_o[w] = (age_i[w] + WayW'(1)) & AgeMask;
      end
      age_o[way_o] = '0;
    end
    if (res_o.fill) begin
      tag_o[way_o]   = lookup_tag_i;
      valid_o[way_o] = 1'b1;
    end
  end

endmodule

### sim/set_assoc_cache_tag_lru_top_test.sv
// Self-checking stream testbench for the set-associative cache tag and LRU controller.
module set_assoc_cache_tag_lru_top_test;
  import sactl_pkg::*;

  localparam int LineBits  = 5;
  localparam int CacheBits = 18;
  localparam int WayBits   = 2;
  localparam int AddrBits  = 32;
  localparam int SetBitsRaw = CacheBits - LineBits - WayBits;
  localparam int SetBits   = (SetBitsRaw > 0) ? SetBitsRaw : 0;
  localparam int NumSets   = 1 << SetBits;
  localparam int NumWays   = 1 << WayBits;
  localparam int TagShift  = SetBits + LineBits;

  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  localparam int RandItems = 1900;
  localparam int HoldAt    = 500;
  localparam int HoldLen   = 400;
  localparam int IdleLimit = 10000;

  typedef struct {
    logic        action;
    logic [31:0] address;
    logic [7:0]  be;
    logic        burst;
    logic        drain;
  } access_t;

  typedef struct {
    logic [1:0]  status;
    logic        hit;
    logic [1:0]  way;
    logic [31:0] addr;
    logic [1:0]  wcode;
    logic        fill;
    logic [31:0] fill_addr;
    logic        wthru;
  } result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  // tag store mirror, one entry per set and way
  logic                valid_q [NumSets][NumWays];
  logic [31:0]         tag_q   [NumSets][NumWays];
  logic [WayBits-1:0]  age_q   [NumSets][NumWays];

  access_t pending_access[$];
  result_t expected_results[$];
  access_t cur;
  int      errs = 0;
  int      sent = 0;
  int      got = 0;
  int      send_gap = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  int      idle_cycles = 0;

  set_assoc_cache_tag_lru_top #(
    .LINE_OFFSET_BITS(LineBits),
    .CACHE_SIZE_BITS (CacheBits),
    .WAY_BITS        (WayBits),
    .ADDRESS_BITS    (AddrBits)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Lookup, allocate on read miss and age the set, as the controller does.
  function automatic result_t cache_lookup(access_t a);
    result_t     r;
    logic        ok;
    logic [2:0]  lane;
    logic [1:0]  wc;
    logic [31:0] adr;
    logic [31:0] tg;
    int          st;
    int          hitw;
    int          lru;
    int          mask;
    logic [WayBits-1:0] cur_age;
    r = '{status: StatusErr, hit: 1'b0, way: '0, addr: '0, wcode: '0,
          fill: 1'b0, fill_addr: '0, wthru: 1'b0};
    ok = a.burst;
    lane = '0;
    wc = WidthDouble;
    if (!a.burst) begin
      // a legal pattern is a contiguous, naturally aligned run of 1, 2, 4 or 8 lanes
      for (int w = 0; w < 4; w++) begin
        for (int l = 0; l < (8 >> w); l++) begin
          mask = ((1 << (1 << w)) - 1) << (l * (1 << w));
          if (a.be == mask) begin
            ok = 1'b1;
            lane = 3'(l);
            wc = 2'(w);
          end
        end
      end
    end
    if (!ok) return r;
    adr = a.address + (32'(lane) << wc);
    if (AddrBits < 32) adr = adr & ((32'd1 << AddrBits) - 1);
    tg = (TagShift >= 32) ? 32'd0 : (adr >> TagShift);
    st = int'((adr >> LineBits) & (NumSets - 1));
    hitw = -1;
    for (int w = 0; w < NumWays; w++) begin
      if (hitw < 0 && valid_q[st][w] && tag_q[st][w] == tg) hitw = w;
    end
    lru = 0;
    for (int w = 0; w < NumWays; w++) begin
      if (age_q[st][w] > age_q[st][lru]) lru = w;
    end
    r.hit = (hitw >= 0);
    r.way = r.hit ? 2'(hitw) : 2'(lru);
    if (a.action == ActRead && !r.hit) begin
      tag_q[st][lru] = tg;
      valid_q[st][lru] = 1'b1;
      r.fill = 1'b1;
      r.fill_addr = ((TagShift >= 32) ? 32'd0 : (tg << TagShift)) | (32'(st) << LineBits);
    end
    if (r.hit || a.action == ActRead) begin
      cur_age = age_q[st][r.way];
      for (int w = 0; w < NumWays; w++) begin
        if (age_q[st][w] < cur_age) age_q[st][w] = age_q[st][w] + 1'b1;
      end
      age_q[st][r.way] = '0;
    end
    r.status = (a.action == ActRead && r.hit) ? StatusHit : StatusMiss;
    r.addr = adr;
    r.wcode = wc;
    r.wthru = (a.action == ActWrite);
    return r;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_access(logic act, logic [31:0] adr, logic [7:0] be, logic bst,
                            logic drn = 1'b0);
    access_t a;
    a = '{action: act, address: adr, be: be, burst: bst, drain: drn};
    pending_access.push_back(a);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errs++;
    end
  endtask

  // driver: present queued accesses, predict each one at its handshake
  always @(posedge clk_i or negedge rst_ni) begin
    logic busy;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_results.push_back(cache_lookup(cur));
        sent++;
        busy = 1'b0;
        send_gap = ((sent / 150) % 3 == 2) ? 0 : pick_gap();
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_access.size() > 0 &&
                     !(pending_access[0].drain && expected_results.size() != 0)) begin
          cur = pending_access.pop_front();
          s_tdata <= {7'b0, cur.burst, cur.be, cur.address};
          s_tuser <= cur.action;
          busy = 1'b1;
        end
      end
      s_tvalid <= busy;
    end
  end

  // monitor: accept results, compare with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    logic    rdy;
    result_t e;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got++;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: %0h", m_tdata);
          errs++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", 32'(e.status), 32'(m_tdata[1:0]));
          check_field("hit_flag", 32'(e.hit), 32'(m_tdata[2]));
          check_field("chosen_way", 32'(e.way), 32'(m_tdata[4:3]));
          check_field("access_address", e.addr, m_tdata[36:5]);
          check_field("width_code", 32'(e.wcode), 32'(m_tdata[38:37]));
          check_field("fill_request", 32'(e.fill), 32'(m_tdata[39]));
          check_field("fill_line_address", e.fill_addr, m_tdata[71:40]);
          check_field("write_through", 32'(e.wthru), 32'(m_tdata[72]));
        end
        // hold off long enough for the pipeline to back up into the input
        if (got == HoldAt) hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if ((got / 150) % 3 != 1 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      m_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  legal_be [15];
    int unsigned set_pool [6];
    int unsigned tag_pool [6];
    logic [31:0] adr;
    logic [7:0]  be;
    logic        bst;
    logic        act;
    int          r;

    legal_be = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                 8'h03, 8'h0C, 8'h30, 8'hC0, 8'h0F, 8'hF0, 8'hFF};
    for (int s = 0; s < NumSets; s++) begin
      for (int w = 0; w < NumWays; w++) begin
        valid_q[s][w] = 1'b0;
        tag_q[s][w] = '0;
        age_q[s][w] = WayBits'(w);
      end
    end

    // fill one set past its ways so the oldest line is evicted, then revisit
    for (int i = 0; i < 5; i++)
      add_access(ActRead, (32'(i + 1) << TagShift) | (32'd7 << LineBits), legal_be[i], 1'b0);
    add_access(ActRead, (32'd1 << TagShift) | (32'd7 << LineBits), legal_be[5], 1'b0);
    add_access(ActRead, (32'd5 << TagShift) | (32'd7 << LineBits), legal_be[6], 1'b0);
    add_access(ActWrite, (32'd5 << TagShift) | (32'd7 << LineBits), legal_be[7], 1'b0);
    add_access(ActWrite, (32'hAA << TagShift) | (32'd7 << LineBits), legal_be[8], 1'b0);
    for (int i = 9; i < 15; i++)
      add_access(i[0] ? ActRead : ActWrite, (32'd3 << TagShift) | (32'd7 << LineBits),
                 legal_be[i], 1'b0);
    add_access(ActRead, 32'h0000_0000, 8'h00, 1'b0);
    add_access(ActWrite, 32'h0000_0040, 8'hA5, 1'b0);
    // burst ignores enables; lane offset wraps past the top of the address space
    add_access(ActRead, 32'hFFFF_FFE7, 8'h00, 1'b1);
    add_access(ActRead, 32'hFFFF_FFFF, 8'h80, 1'b0);

    for (int i = 0; i < 6; i++) begin
      set_pool[i] = $urandom_range(0, NumSets - 1);
      tag_pool[i] = $urandom_range(0, 65535);
    end
    for (int i = 0; i < RandItems; i++) begin
      r = $urandom_range(0, 99);
      if (r < 88) begin
        adr = (32'(tag_pool[$urandom_range(0, 5)]) << TagShift) |
              (32'(set_pool[$urandom_range(0, 5)]) << LineBits) |
              32'($urandom_range(0, (1 << LineBits) - 1));
      end else begin
        adr = $urandom;
      end
      r = $urandom_range(0, 99);
      bst = 1'b0;
      if (r < 75) be = legal_be[$urandom_range(0, 14)];
      else if (r < 88) be = 8'($urandom);
      else begin
        be = 8'($urandom);
        bst = 1'b1;
      end
      act = ($urandom_range(0, 99) < 60) ? ActRead : ActWrite;
      // midway, hold the next access back until every result is in
      add_access(act, adr, be, bst, i == RandItems / 2);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample between edges so the driver's and monitor's updates have settled
    while (pending_access.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sactl_pkg.sv
hw/rtl/sactl_way_ctrl.sv
hw/rtl/set_assoc_cache_tag_lru_top.sv
sim/set_assoc_cache_tag_lru_top_test.sv
